>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks itself, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, quiet while reset is asserted.
`define RWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, built on the non-overlapping implication of pre and post.
`define RWC_ASSERT_NEXT(label, pre, post, msg) \
	`RWC_ASSERT(label, (pre) |=> (post), msg)

`endif

>>> hw/rtl/rwc_pkg.sv
`timescale 1ns / 1ps

package rwc_pkg;

	// Window geometry.
	localparam int BITMAP_BITS = 2048;
	localparam int WORD_BITS   = 64;
	localparam int WINDOW_SIZE = 1984;
	localparam int RING_WORDS  = BITMAP_BITS / WORD_BITS;
	localparam int RING_AW     = $clog2(RING_WORDS);
	localparam int BIT_AW      = $clog2(WORD_BITS);
	localparam int CNT_W       = RING_AW + 1;

	// Field and datapath widths.
	localparam int NONCE_W = 64;
	localparam int ALU_W   = NONCE_W + 1;
	localparam int ADDR_W  = 4;

	localparam logic [NONCE_W-1:0] REJECT_AFTER_RST = 64'd18446744073709549630;
	localparam logic [ADDR_W-1:0]  REG_REJECT_AFTER = 4'h0;

	// Sequencer steps.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIM_TOP,
		ST_LIM_NONCE,
		ST_INC,
		ST_WIN,
		ST_STALE,
		ST_ADV,
		ST_SPAN,
		ST_CLEAR,
		ST_READ,
		ST_TEST,
		ST_DONE
	} rwc_state_t;

	// One operation for the shared adder: a + b + cin, or a - b when sub and cin are both set.
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
		logic             cin;
	} rwc_alu_req_t;

	// Status from the sequencer to the top level.
	typedef struct packed {
		logic               busy;
		logic [NONCE_W-1:0] hpo;
	} rwc_status_t;

endpackage

>>> hw/rtl/rwc_ram.sv
`timescale 1ns / 1ps

module rwc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hw/rtl/rwc_alu.sv
`timescale 1ns / 1ps

module rwc_alu
	import rwc_pkg::*;
(
	input  rwc_alu_req_t     req,
	output logic [ALU_W:0]   res
);

	logic [ALU_W-1:0] opb;

	// Subtraction is a + ~b + 1; the top bit is the carry, set when a >= b.
	assign opb = req.sub ? ~req.b : req.b;
	assign res = {1'b0, req.a} + {1'b0, opb} + {{ALU_W{1'b0}}, req.cin};

endmodule

>>> hw/rtl/rwc_ctrl.sv
`timescale 1ns / 1ps

module rwc_ctrl
	import rwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [NONCE_W-1:0] s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	input  logic [NONCE_W-1:0] reject_after,
	output rwc_status_t        status
);

	rwc_state_t state_q, state_nxt;

	logic [NONCE_W-1:0]   nonce_q;
	logic [NONCE_W-1:0]   t_q;
	logic [ALU_W-1:0]     win_q;
	logic [NONCE_W-1:0]   hpo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RING_AW-1:0]   ptr_q;
	logic                 result_q;
	logic                 m_valid_q;
	logic                 m_data_q;
	logic [RING_WORDS-1:0] vld_q;

	rwc_alu_req_t         alu_req;
	logic [ALU_W:0]       alu_res;
	logic                 alu_carry;
	logic [ALU_W-1:0]     span_dif;
	logic [CNT_W-1:0]     span_cnt;

	logic                 ram_we;
	logic [RING_AW-1:0]   ram_addr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [RING_AW-1:0]   slot;
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 was_set;
	logic                 out_free;

	rwc_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	rwc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (RING_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign alu_carry = alu_res[ALU_W];

	// Word distance, capped at the ring size.
	assign span_dif = alu_res[ALU_W-1:0];
	assign span_cnt = ((|span_dif[ALU_W-1:CNT_W]) || (span_dif[CNT_W-1:0] > CNT_W'(RING_WORDS)))
		? CNT_W'(RING_WORDS) : span_dif[CNT_W-1:0];

	// Bit lookup for t_q, the nonce plus one; a word never written reads as zero.
	assign slot     = t_q[BIT_AW +: RING_AW];
	assign bit_mask = WORD_BITS'(1) << t_q[BIT_AW-1:0];
	assign cur_word = vld_q[slot] ? ram_rdata : '0;
	assign was_set  = |(cur_word & bit_mask);
	assign out_free = !m_valid_q || m_tready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, adder operands and RAM port.
	always_comb begin
		state_nxt = state_q;
		alu_req   = '0;
		ram_we    = 1'b0;
		ram_addr  = slot;
		ram_wdata = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = ST_LIM_TOP;
				end
			end
			ST_LIM_TOP: begin
				alu_req = '{a: {1'b0, reject_after}, b: {1'b0, hpo_q}, sub: 1'b1, cin: 1'b1};
				state_nxt = alu_carry ? ST_LIM_NONCE : ST_DONE;
			end
			ST_LIM_NONCE: begin
				alu_req = '{a: {1'b0, nonce_q}, b: {1'b0, reject_after}, sub: 1'b1, cin: 1'b1};
				state_nxt = alu_carry ? ST_DONE : ST_INC;
			end
			ST_INC: begin
				alu_req = '{a: {1'b0, nonce_q}, b: '0, sub: 1'b0, cin: 1'b1};
				state_nxt = ST_WIN;
			end
			ST_WIN: begin
				alu_req = '{a: {1'b0, t_q}, b: ALU_W'(WINDOW_SIZE), sub: 1'b0, cin: 1'b0};
				state_nxt = ST_STALE;
			end
			ST_STALE: begin
				alu_req = '{a: win_q, b: {1'b0, hpo_q}, sub: 1'b1, cin: 1'b1};
				state_nxt = alu_carry ? ST_ADV : ST_DONE;
			end
			ST_ADV: begin
				alu_req = '{a: {1'b0, hpo_q}, b: {1'b0, t_q}, sub: 1'b1, cin: 1'b1};
				state_nxt = alu_carry ? ST_READ : ST_SPAN;
			end
			ST_SPAN: begin
				alu_req = '{a: {1'b0, t_q} >> BIT_AW, b: {1'b0, hpo_q} >> BIT_AW,
					sub: 1'b1, cin: 1'b1};
				state_nxt = ST_CLEAR;
			end
			ST_CLEAR: begin
				ram_addr = ptr_q;
				if (cnt_q == '0) begin
					state_nxt = ST_READ;
				end else begin
					ram_we = 1'b1;
				end
			end
			ST_READ: begin
				state_nxt = ST_TEST;
			end
			ST_TEST: begin
				ram_we    = 1'b1;
				ram_wdata = cur_word | bit_mask;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Window top and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpo_q <= '0;
			vld_q <= '0;
		end else begin
			if (state_q == ST_CLEAR && cnt_q == '0) begin
				hpo_q <= t_q;
			end
			if (ram_we) begin
				vld_q[ram_addr] <= 1'b1;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				nonce_q  <= s_tdata;
				result_q <= 1'b0;
			end
			ST_INC: begin
				t_q <= alu_res[NONCE_W-1:0];
			end
			ST_WIN: begin
				win_q <= alu_res[ALU_W-1:0];
			end
			ST_SPAN: begin
				cnt_q <= span_cnt;
				ptr_q <= RING_AW'(hpo_q[BIT_AW +: RING_AW] + 1'b1);
			end
			ST_CLEAR: begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					ptr_q <= RING_AW'(ptr_q + 1'b1);
				end
			end
			ST_TEST: begin
				result_q <= !was_set;
			end
			default: begin
			end
		endcase
	end

	// Output register: holds the verdict until the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= result_q;
		end
	end

	assign m_tvalid    = m_valid_q;
	assign m_tdata     = {7'b0, m_data_q};
	assign status.busy = (state_q != ST_IDLE);
	assign status.hpo  = hpo_q;

endmodule

>>> hw/rtl/replay_window_check_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tdata[63:0] = nonce
// m_axis    out  tdata[7:0]  = accepted in bit 0, zeros above
// apb       in   register reject_after at byte address 0x0, 64 bits
//
// A nonce at or over the limit, or behind the window, gets its result without a bitmap read;
// advancing the top adds the span step, one clearing step per word cleared (up to the
// whole ring of 32 words) and a final clearing step that moves the top.
// The limit, window and span compares and adds share one 65-bit adder, one step
// per cycle; clearing skipped words takes one RAM write per word. Reset clears the
// window top and the per-word valid bits at once, so no clearing pass follows reset.
// The input is not ready while an item is in work; a stalled result is held.
`include "assert_macros.svh"

module replay_window_check_top
	import rwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,   // [63:0] nonce
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [0] accepted, [7:1] zero
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	logic [NONCE_W-1:0] reject_after_q;
	rwc_status_t        status;

	// Limit register, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_after_q <= REJECT_AFTER_RST;
		end else if (psel && penable && pwrite && paddr[3] == REG_REJECT_AFTER[3]) begin
			reject_after_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_REJECT_AFTER[3]) ? reject_after_q : '0;

	rwc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.reject_after (reject_after_q),
		.status       (status)
	);

	// An accepted nonce keeps the input closed on the next cycle.
	`RWC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && status.busy, "input open right after accept")

	// A result appears only after work with the input closed.
	`RWC_ASSERT(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without work")

	// The window top never moves backward.
	`RWC_ASSERT(a_top_monotonic, status.hpo >= $past(status.hpo), "window top decreased")

endmodule
